/* design/rlge_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_pkg
// Shared types and constants of the run-length group encoder.
// ----------------------------------------------------------------------------
package rlge_pkg;

    localparam int unsigned          TABLE_DEPTH_DEF = 1024;
    localparam int unsigned          KEY_WIDTH_DEF   = 64;
    localparam longint unsigned      RUN_MAX_DEF     = 64'd65535;

    // Port field widths
    localparam int unsigned KEY_IN_W  = 64;
    localparam int unsigned GROUP_O_W = 11;
    localparam int unsigned LEN_O_W   = 16;

    // Table entries carry an epoch mark; a mark unequal to the current one reads as empty
    localparam int unsigned EPOCH_W = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [GROUP_O_W-1:0] group_number;
        logic [LEN_O_W-1:0]   run_length;
        logic                 final_run;
        logic [GROUP_O_W-1:0] distinct_count;
        logic                 table_full;
    } t_result;

endpackage
`default_nettype wire

/* design/rlge_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_if
// Handshake channels of the encoder: element items in, run items out.
// ----------------------------------------------------------------------------
interface rlge_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_value;
    logic        final_element;

    modport source (output valid, output key_value, output final_element, input ready);
    modport sink   (input valid, input key_value, input final_element, output ready);
endinterface

interface rlge_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] group_number;
    logic [15:0] run_length;
    logic        final_run;
    logic [10:0] distinct_count;
    logic        table_full;

    modport source (output valid, output group_number, output run_length, output final_run,
                    output distinct_count, output table_full, input ready);
    modport sink   (input valid, input group_number, input run_length, input final_run,
                    input distinct_count, input table_full, output ready);
endinterface
`default_nettype wire

/* design/rlge_slot_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_slot_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rlge_slot_mem
    import rlge_pkg::*;
#(
    parameter int unsigned DEPTH  = TABLE_DEPTH_DEF,
    parameter int unsigned DATA_W = 8
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [DATA_W-1:0]        i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]       o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* design/rlge_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlge_out_stage
// Output register for run items; takes a new item while the old one leaves.
// ----------------------------------------------------------------------------
module rlge_out_stage
    import rlge_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  t_result      i_data,
    output logic         o_can_push,
    rlge_out_if.source   o_run
);

    logic    r_valid;
    t_result r_data;

    assign o_can_push = !r_valid || o_run.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_run.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_run.valid          = r_valid;
    assign o_run.group_number   = r_data.group_number;
    assign o_run.run_length     = r_data.run_length;
    assign o_run.final_run      = r_data.final_run;
    assign o_run.distinct_count = r_data.distinct_count;
    assign o_run.table_full     = r_data.table_full;

endmodule
`default_nettype wire

/* design/run_length_group_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_group_encoder
// Cuts a key vector into runs of equal keys, numbers each distinct key.
// ----------------------------------------------------------------------------
// i_item takes one key per vector element, final_element on the last one.
// o_run gives one item per run: group number (first-seen order, 0 when the
// table has no room), length (saturating at RUN_MAX), and on the vector's
// last run final_run with the distinct key count.
// An element that extends the open run is taken in the idle state. A key
// that opens a new run is registered, then hashed and read, then compared;
// each extra linear probe adds one more read and compare on the slot
// memory's single read port. A final element that opens a run then flushes.
// The open run's item is written to the output register when the next run
// starts; items are accepted while the output register is free or drains in
// the same cycle, so a stalled receiver holds off input after one item.
// Reset starts a clearing pass over every slot of the slot memory, during
// which no item is accepted. Emptying the table at a vector's end is an
// epoch step; every 255th vector a clearing pass runs again.
// ----------------------------------------------------------------------------
module run_length_group_encoder
    import rlge_pkg::*;
#(
    parameter int unsigned     TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int unsigned     KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter longint unsigned RUN_MAX     = RUN_MAX_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rlge_in_if.sink     i_item,
    rlge_out_if.source  o_run
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned GRP_W  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LEN_W  = $clog2(RUN_MAX + 1);
    localparam int unsigned WORD_W = EPOCH_W + GRP_W + KEY_WIDTH;

    t_state                 r_state, n_state;
    logic [KEY_WIDTH-1:0]   r_prev_key, n_prev_key;
    logic [GRP_W-1:0]       r_group, n_group;
    logic [LEN_W-1:0]       r_len, n_len;
    logic                   r_open, n_open;
    logic [GRP_W-1:0]       r_used, n_used;
    logic                   r_final_pend, n_final_pend;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [GRP_W-1:0]       r_probes, n_probes;
    logic [EPOCH_W-1:0]     r_epoch, n_epoch;

    logic                   wr_en, rd_en;
    logic [ADDR_W-1:0]      wr_addr, rd_addr;
    logic [WORD_W-1:0]      wr_data, rd_data;
    logic [EPOCH_W-1:0]     rd_epoch;
    logic [GRP_W-1:0]       rd_group;
    logic [KEY_WIDTH-1:0]   rd_key;

    logic                   push, can_push;
    t_result                push_data;

    logic [KEY_WIDTH-1:0]   in_key;
    logic [ADDR_W-1:0]      fold, home, next_addr;
    logic [LEN_W-1:0]       len_inc;
    logic [GRP_W-1:0]       found_group;
    logic                   found;

    assign in_key = i_item.key_value[KEY_WIDTH-1:0];
    assign {rd_epoch, rd_group, rd_key} = rd_data;
    assign len_inc = (r_len < LEN_W'(RUN_MAX)) ? LEN_W'(r_len + 1'b1) : r_len;
    assign next_addr = (r_addr == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : ADDR_W'(r_addr + 1'b1);

    // Home slot: xor-fold of the key, brought into range by one subtract
    always_comb begin
        fold = '0;
        for (int i = 0; i < KEY_WIDTH; i++) begin
            fold[i % ADDR_W] = fold[i % ADDR_W] ^ r_prev_key[i];
        end
        if ({1'b0, fold} >= (ADDR_W + 1)'(TABLE_DEPTH)) begin
            home = ADDR_W'(fold - ADDR_W'(TABLE_DEPTH));
        end else begin
            home = fold;
        end
    end

    rlge_slot_mem #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (WORD_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rlge_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_data),
        .o_can_push (can_push),
        .o_run      (o_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_open       <= 1'b0;
            r_used       <= '0;
            r_group      <= '0;
            r_len        <= '0;
            r_final_pend <= 1'b0;
            r_addr       <= '0;
            r_probes     <= '0;
            r_epoch      <= EPOCH_W'(1);
        end else begin
            r_state      <= n_state;
            r_open       <= n_open;
            r_used       <= n_used;
            r_group      <= n_group;
            r_len        <= n_len;
            r_final_pend <= n_final_pend;
            r_addr       <= n_addr;
            r_probes     <= n_probes;
            r_epoch      <= n_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_key <= n_prev_key;
    end

    always_comb begin
        n_state      = r_state;
        n_prev_key   = r_prev_key;
        n_group      = r_group;
        n_len        = r_len;
        n_open       = r_open;
        n_used       = r_used;
        n_final_pend = r_final_pend;
        n_addr       = r_addr;
        n_probes     = r_probes;
        n_epoch      = r_epoch;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        push         = 1'b0;
        push_data    = '0;
        i_item.ready = 1'b0;
        found        = 1'b0;
        found_group  = '0;

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                if (r_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                    n_addr  = '0;
                    n_epoch = EPOCH_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_addr = ADDR_W'(r_addr + 1'b1);
                end
            end

            ST_IDLE: begin
                i_item.ready = can_push;
                if (i_item.valid && can_push) begin
                    if (r_open && in_key == r_prev_key) begin
                        n_len = len_inc;
                        if (i_item.final_element) begin
                            push                     = 1'b1;
                            push_data.group_number   = GROUP_O_W'(r_group);
                            push_data.run_length     = LEN_O_W'(len_inc);
                            push_data.final_run      = 1'b1;
                            push_data.distinct_count = GROUP_O_W'(r_used);
                            push_data.table_full     = (r_group == '0);
                        end
                    end else begin
                        if (r_open) begin
                            push                   = 1'b1;
                            push_data.group_number = GROUP_O_W'(r_group);
                            push_data.run_length   = LEN_O_W'(r_len);
                            push_data.table_full   = (r_group == '0);
                        end
                        n_prev_key   = in_key;
                        n_final_pend = i_item.final_element;
                        n_state      = ST_HASH;
                    end
                end
            end

            ST_HASH: begin
                rd_en    = 1'b1;
                rd_addr  = home;
                n_addr   = home;
                n_probes = '0;
                n_state  = ST_PROBE;
            end

            ST_PROBE: begin
                if (rd_epoch != r_epoch) begin
                    // empty slot: enter the key as the next group
                    wr_en       = 1'b1;
                    wr_addr     = r_addr;
                    wr_data     = {r_epoch, GRP_W'(r_used + 1'b1), r_prev_key};
                    n_used      = GRP_W'(r_used + 1'b1);
                    found       = 1'b1;
                    found_group = GRP_W'(r_used + 1'b1);
                end else if (rd_key == r_prev_key) begin
                    found       = 1'b1;
                    found_group = rd_group;
                end else if (r_probes == GRP_W'(TABLE_DEPTH - 1)) begin
                    found       = 1'b1;
                    found_group = '0;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = next_addr;
                    n_addr   = next_addr;
                    n_probes = GRP_W'(r_probes + 1'b1);
                end
                if (found) begin
                    n_group = found_group;
                    n_len   = LEN_W'(1);
                    n_open  = 1'b1;
                    n_state = r_final_pend ? ST_FLUSH : ST_IDLE;
                end
            end

            ST_FLUSH: begin
                if (can_push) begin
                    push                     = 1'b1;
                    push_data.group_number   = GROUP_O_W'(r_group);
                    push_data.run_length     = LEN_O_W'(r_len);
                    push_data.final_run      = 1'b1;
                    push_data.distinct_count = GROUP_O_W'(r_used);
                    push_data.table_full     = (r_group == '0);
                    n_state                  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // end of vector: close out the run, step the epoch or sweep the table
        if (push && push_data.final_run) begin
            n_open       = 1'b0;
            n_used       = '0;
            n_group      = '0;
            n_len        = '0;
            n_final_pend = 1'b0;
            if (r_epoch == '1) begin
                n_addr  = '0;
                n_state = ST_CLEAR;
            end else begin
                n_epoch = EPOCH_W'(r_epoch + 1'b1);
                n_state = ST_IDLE;
            end
        end
    end

endmodule
`default_nettype wire
